// ----- src/lssd_pkg.sv -----
// shared types and constants for the lsb stego stream decoder
package lssd_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [15:0] MAGIC_RESET = 16'd9002;

	localparam logic [1:0] KIND_EXT       = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
	localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
	localparam logic [1:0] KIND_EMPTY     = 2'd3;

	typedef struct packed {
		logic start;
		logic lsb;
	} q_entry_t;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} res_t;

endpackage

// ----- src/lssd_front.sv -----
// front end: takes image bytes, skips the header, queues carrier bits
module lssd_front #(
	parameter int HEADER_BYTES = 54
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tuser,
	output logic                push_valid,
	input  logic                push_ready,
	output lssd_pkg::q_entry_t  push_data
);

	localparam int HCW = (HEADER_BYTES > 0) ? $clog2(HEADER_BYTES + 1) : 1;

	logic [HCW-1:0] hdr_cnt_q;
	logic [HCW-1:0] hdr_eff;
	logic           pend_start_q;
	logic           accept;
	logic           in_header;

	assign s_tready  = push_ready;
	assign accept    = s_tvalid && push_ready;
	assign hdr_eff   = s_tuser ? '0 : hdr_cnt_q;
	assign in_header = hdr_eff < HCW'(HEADER_BYTES);

	assign push_valid      = accept && !in_header;
	assign push_data.start = s_tuser || pend_start_q;
	assign push_data.lsb   = s_tdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q    <= '0;
			pend_start_q <= 1'b1;
		end else if (accept) begin
			if (in_header) begin
				hdr_cnt_q    <= hdr_eff + HCW'(1);
				pend_start_q <= 1'b1;
			end else begin
				hdr_cnt_q    <= hdr_eff;
				pend_start_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/lssd_queue.sv -----
// small fifo between the front end and the decoder
module lssd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  lssd_pkg::q_entry_t  push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output lssd_pkg::q_entry_t  pop_data
);

	localparam int AW = $clog2(lssd_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(lssd_pkg::QUEUE_DEPTH + 1);

	lssd_pkg::q_entry_t mem_q [lssd_pkg::QUEUE_DEPTH];
	logic [AW-1:0]      wr_ptr_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != CW'(lssd_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- src/lssd_back.sv -----
// decoder back end: gathers bits, walks magic, lengths and bytes, drives the result register
module lssd_back #(
	parameter int MAGIC_BYTES = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         magic,
	input  logic                q_valid,
	output logic                q_ready,
	input  lssd_pkg::q_entry_t  q_data,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic [1:0]          m_tuser,
	output logic                m_tlast
);

	localparam logic [2:0] PH_MAGIC    = 3'd1;
	localparam logic [2:0] PH_EXT_LEN  = 3'd2;
	localparam logic [2:0] PH_EXT      = 3'd3;
	localparam logic [2:0] PH_DATA_LEN = 3'd4;
	localparam logic [2:0] PH_DATA     = 3'd5;
	localparam logic [2:0] PH_IDLE     = 3'd6;

	localparam int         MW         = 8 * MAGIC_BYTES;
	localparam logic [5:0] MAGIC_NEED = 6'(MW);
	localparam logic [5:0] WORD_NEED  = 6'd32;
	localparam logic [5:0] BYTE_NEED  = 6'd8;

	logic [2:0]       phase_q;
	logic [4:0]       bit_count_q;
	logic [31:0]      shift_q;
	logic [31:0]      items_q;
	logic             out_valid_q;
	lssd_pkg::res_t   out_q;

	logic [2:0]       ph;
	logic [4:0]       bc;
	logic [31:0]      sh;
	logic [31:0]      sh_nx;
	logic [5:0]       bc_inc;
	logic [5:0]       need;
	logic             done;
	logic [31:0]      len;
	logic             can_load;
	logic             pop;
	logic [2:0]       phase_nx;
	logic [31:0]      items_nx;
	logic             res_valid;
	lssd_pkg::res_t   res;

	assign can_load = !out_valid_q || m_tready;
	assign pop      = q_valid && can_load;
	assign q_ready  = can_load;

	assign ph     = q_data.start ? PH_MAGIC : phase_q;
	assign bc     = q_data.start ? 5'd0 : bit_count_q;
	assign sh     = q_data.start ? 32'd0 : shift_q;
	assign sh_nx  = {sh[30:0], q_data.lsb};
	assign bc_inc = {1'b0, bc} + 6'd1;
	assign need   = (ph == PH_MAGIC) ? MAGIC_NEED :
		(ph inside {PH_EXT_LEN, PH_DATA_LEN}) ? WORD_NEED : BYTE_NEED;
	assign done   = bc_inc >= need;
	assign len    = sh_nx[31] ? 32'd0 : sh_nx;

	always_comb begin
		phase_nx  = ph;
		items_nx  = items_q;
		res_valid = 1'b0;
		res.data  = sh_nx[7:0];
		res.kind  = lssd_pkg::KIND_EXT;
		res.last  = 1'b0;
		case (ph)
			PH_MAGIC: begin
				if (done) begin
					if (sh_nx[MW-1:0] != magic[15 -: MW]) begin
						phase_nx  = PH_IDLE;
						res_valid = 1'b1;
						res.data  = 8'd0;
						res.kind  = lssd_pkg::KIND_BAD_MAGIC;
						res.last  = 1'b1;
					end else begin
						phase_nx = PH_EXT_LEN;
					end
				end
			end
			PH_EXT_LEN: begin
				if (done) begin
					items_nx = len;
					phase_nx = (len == 32'd0) ? PH_DATA_LEN : PH_EXT;
				end
			end
			PH_EXT: begin
				if (done) begin
					items_nx  = items_q - 32'd1;
					res_valid = 1'b1;
					res.kind  = lssd_pkg::KIND_EXT;
					if (items_q == 32'd1) begin
						phase_nx = PH_DATA_LEN;
					end
				end
			end
			PH_DATA_LEN: begin
				if (done) begin
					items_nx = len;
					if (len == 32'd0) begin
						phase_nx  = PH_IDLE;
						res_valid = 1'b1;
						res.data  = 8'd0;
						res.kind  = lssd_pkg::KIND_EMPTY;
						res.last  = 1'b1;
					end else begin
						phase_nx = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (done) begin
					items_nx  = items_q - 32'd1;
					res_valid = 1'b1;
					res.kind  = lssd_pkg::KIND_PAYLOAD;
					if (items_q == 32'd1) begin
						phase_nx = PH_IDLE;
						res.last = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAGIC;
			bit_count_q <= '0;
			shift_q     <= '0;
			items_q     <= '0;
		end else if (pop) begin
			phase_q <= phase_nx;
			items_q <= items_nx;
			if (ph != PH_IDLE) begin
				shift_q     <= sh_nx;
				bit_count_q <= done ? 5'd0 : bc_inc[4:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= pop && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.data;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		pop && res_valid && res.last |=> phase_q == PH_IDLE)
		else $error("final result did not leave the decoder idle");

	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.kind == lssd_pkg::KIND_BAD_MAGIC ||
			out_q.kind == lssd_pkg::KIND_EMPTY) |-> out_q.data == 8'd0 && out_q.last)
		else $error("status result carries data or lacks last");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		pop && phase_q == PH_IDLE && !q_data.start |-> !res_valid)
		else $error("result produced while idle");

endmodule

// ----- src/lsb_stego_stream_decoder.sv -----
// top level of the lsb stego stream decoder
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    tdata[7:0] image_byte, tuser restart
// m_       out  m_tvalid/m_tready    tdata[7:0] out_byte, tuser[1:0] out_kind, tlast last
// cfg_     in   cfg_valid/cfg_ready  data[15:0] magic_value
//
// one image byte per cycle while the fifo has room; results are registered after the fifo
// header bytes are dropped in the front end, carrier bits wait in a four entry fifo
// the decoder stalls on m_tready through its single result register, the front on a full fifo
// reset clears all control state and loads magic_value with 9002; cfg_ready is always high
module lsb_stego_stream_decoder #(
	parameter int HEADER_BYTES = 54,
	parameter int MAGIC_BYTES  = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // image_byte
	input  logic        s_tuser,   // restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic [1:0]  m_tuser,   // out_kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic               push_valid;
	logic               push_ready;
	lssd_pkg::q_entry_t push_data;
	logic               pop_valid;
	logic               pop_ready;
	lssd_pkg::q_entry_t pop_data;
	logic [15:0]        magic_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= lssd_pkg::MAGIC_RESET;
		end else if (cfg_valid) begin
			magic_q <= cfg_data;
		end
	end

	lssd_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	lssd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	lssd_back #(
		.MAGIC_BYTES(MAGIC_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.magic   (magic_q),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.q_data  (pop_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ----- sim/lsb_stego_stream_decoder_tb.sv -----
// testbench for the lsb stego stream decoder, with a scoreboard that decodes the carrier alongside
class lsb_decode_score;
	typedef enum logic [2:0] {
		ST_HEADER, ST_MAGIC, ST_EXT_LEN, ST_EXT, ST_DATA_LEN, ST_DATA, ST_IDLE
	} dec_phase_t;

	int             hdr_bytes;
	int             magic_bytes;
	logic [15:0]    magic;
	dec_phase_t     ph;
	int unsigned    hdr_cnt;
	int unsigned    nbits;
	logic [31:0]    shreg;
	logic [31:0]    bytes_left;
	lssd_pkg::res_t pending_out[$];
	int             errors;

	function new(int hb, int mb);
		hdr_bytes = hb;
		magic_bytes = mb;
		magic = lssd_pkg::MAGIC_RESET;
		errors = 0;
		clear();
	endfunction

	function void clear();
		ph = ST_HEADER;
		hdr_cnt = 0;
		nbits = 0;
		shreg = '0;
		bytes_left = '0;
	endfunction

	function bit shift_in(logic b, int unsigned need);
		bit done;
		shreg = {shreg[30:0], b};
		done = (nbits + 1 >= need);
		nbits = done ? 0 : nbits + 1;
		return done;
	endfunction

	function void push_out(logic [7:0] d, logic [1:0] k, logic l);
		lssd_pkg::res_t r;
		r.data = d;
		r.kind = k;
		r.last = l;
		pending_out.push_back(r);
	endfunction

	// one accepted image byte
	function void take_byte(logic [7:0] b, logic rs);
		logic [31:0] len;
		logic        ok;
		if (rs)
			clear();
		if (ph == ST_HEADER) begin
			if (hdr_cnt < hdr_bytes) begin
				hdr_cnt++;
				return;
			end
			ph = ST_MAGIC;
			nbits = 0;
			shreg = '0;
		end
		case (ph)
			ST_MAGIC: begin
				if (shift_in(b[0], 8 * magic_bytes)) begin
					ok = (magic_bytes >= 2) ? (shreg[15:0] == magic)
						: (shreg[7:0] == magic[15:8]);
					if (!ok) begin
						ph = ST_IDLE;
						push_out(8'h00, lssd_pkg::KIND_BAD_MAGIC, 1'b1);
					end else begin
						ph = ST_EXT_LEN;
					end
				end
			end
			ST_EXT_LEN: begin
				if (shift_in(b[0], 32)) begin
					len = shreg[31] ? 32'd0 : shreg;
					bytes_left = len;
					ph = (len == 0) ? ST_DATA_LEN : ST_EXT;
				end
			end
			ST_EXT: begin
				if (shift_in(b[0], 8)) begin
					bytes_left--;
					if (bytes_left == 0)
						ph = ST_DATA_LEN;
					push_out(shreg[7:0], lssd_pkg::KIND_EXT, 1'b0);
				end
			end
			ST_DATA_LEN: begin
				if (shift_in(b[0], 32)) begin
					len = shreg[31] ? 32'd0 : shreg;
					bytes_left = len;
					if (len == 0) begin
						ph = ST_IDLE;
						push_out(8'h00, lssd_pkg::KIND_EMPTY, 1'b1);
					end else begin
						ph = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				if (shift_in(b[0], 8)) begin
					bytes_left--;
					if (bytes_left == 0) begin
						ph = ST_IDLE;
						push_out(shreg[7:0], lssd_pkg::KIND_PAYLOAD, 1'b1);
					end else begin
						push_out(shreg[7:0], lssd_pkg::KIND_PAYLOAD, 1'b0);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function void check_out(lssd_pkg::res_t got);
		lssd_pkg::res_t want;
		if (pending_out.size() == 0) begin
			errors++;
			$display("%0t unexpected result: data %02h kind %0d last %0b",
				$time, got.data, got.kind, got.last);
			return;
		end
		want = pending_out.pop_front();
		if (got.data !== want.data) begin
			errors++;
			$display("%0t out_byte mismatch: expected %02h actual %02h", $time, want.data, got.data);
		end
		if (got.kind !== want.kind) begin
			errors++;
			$display("%0t out_kind mismatch: expected %0d actual %0d", $time, want.kind, got.kind);
		end
		if (got.last !== want.last) begin
			errors++;
			$display("%0t last mismatch: expected %0b actual %0b", $time, want.last, got.last);
		end
	endfunction
endclass

module lsb_stego_stream_decoder_tb #(
	parameter int HEADER_BYTES = 54,
	parameter int MAGIC_BYTES  = 2
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 300;
	localparam int TARGET_ITEMS  = 1650;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // image_byte
	logic        s_tuser = 1'b0;  // restart
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // out_byte
	logic [1:0]  m_tuser;         // out_kind
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	lsb_decode_score sb;
	int items_sent = 0;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;
	bit hold_req = 1'b0;

	lsb_stego_stream_decoder #(
		.HEADER_BYTES(HEADER_BYTES),
		.MAGIC_BYTES (MAGIC_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result sink
	initial begin
		int wt;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			wt = no_gaps ? 0 : $urandom_range(0, 3);
			if (wt > 0) begin
				m_tready = 1'b0;
				repeat (wt) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_out(lssd_pkg::res_t'{data: m_tdata, kind: m_tuser, last: m_tlast});
			@(negedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic rs);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tuser = rs;
		do @(posedge clk); while (!s_tready);
		sb.take_byte(b, rs);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// msb first, one bit per carrier byte, upper seven bits random
	function automatic void add_bits(ref logic [7:0] img[$], input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			img.push_back({7'($urandom), v[i]});
	endfunction

	task automatic send_file(input logic [15:0] mg, input logic [31:0] ext_word, input int ext_n,
		input logic [31:0] pay_word, input int pay_n, input int cut);
		logic [7:0] img[$];
		repeat (HEADER_BYTES) img.push_back(8'($urandom));
		if (MAGIC_BYTES >= 2)
			add_bits(img, {16'd0, mg}, 16);
		else
			add_bits(img, {24'd0, mg[15:8]}, 8);
		add_bits(img, ext_word, 32);
		repeat (ext_n) add_bits(img, {24'd0, pick_byte()}, 8);
		add_bits(img, pay_word, 32);
		repeat (pay_n) add_bits(img, {24'd0, pick_byte()}, 8);
		if (cut > 0)
			while (img.size() > cut) void'(img.pop_back());
		foreach (img[i])
			send_byte(img[i], i == 0);
	endtask

	task automatic noise(input int n, input int restart_odds);
		repeat (n) send_byte(8'($urandom), $urandom_range(0, restart_odds) == 0);
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (sb.pending_out.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_magic(input logic [15:0] v);
		settle();
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.magic = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		int          kind;
		int          en;
		int          pn;
		int          files;
		logic [31:0] ew;
		logic [31:0] pw;
		sb = new(HEADER_BYTES, MAGIC_BYTES);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed files under the reset magic, then the register extremes
		no_gaps = 1'b1;
		send_file(sb.magic, 32'd0, 0, 32'd0, 0, 0);
		noise(3, 1000);
		no_gaps = 1'b0;
		send_file(sb.magic, 32'd2, 2, 32'd3, 3, 0);
		send_file(sb.magic ^ 16'h0100, 32'd0, 0, 32'd1, 1, 0);
		send_file(sb.magic, 32'h8000_0000, 0, 32'hFFFF_FFFF, 0, 0);
		write_magic(16'h0000);
		send_file(16'h0000, 32'd1, 1, 32'd2, 2, 0);
		write_magic(16'hFFFF);
		send_file(16'hFFFF, 32'd0, 0, 32'd1, 1, 0);
		send_file(16'h7FFF, 32'd0, 0, 32'd1, 1, 0);

		files = 0;
		while (items_sent < TARGET_ITEMS) begin
			if (files % 4 == 3) begin
				case ($urandom_range(0, 4))
					0: write_magic(16'h0000);
					1: write_magic(16'hFFFF);
					2: write_magic(lssd_pkg::MAGIC_RESET);
					default: write_magic(16'($urandom));
				endcase
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			en = $urandom_range(0, 3);
			pn = $urandom_range(0, 8);
			if (files == 2) begin
				// long receiver stall so the input side backs up
				kind = 9;
				en = 1;
				pn = 8;
				no_gaps = 1'b1;
				hold_req = 1'b1;
			end
			ew = en;
			pw = pn;
			if (en == 0 && $urandom_range(0, 1))
				ew = {1'b1, 31'($urandom)};
			if (pn == 0 && $urandom_range(0, 1))
				pw = {1'b1, 31'($urandom)};
			case (kind)
				0: send_file(sb.magic ^ 16'(1 << $urandom_range(0, 15)), ew, en, pw, pn, 0);
				1: noise($urandom_range(1, 40), 7);
				2: send_file(sb.magic, {1'b0, 31'($urandom)}, 3, pw, pn,
					$urandom_range(1, HEADER_BYTES + 150));
				default: send_file(sb.magic, ew, en, pw, pn, 0);
			endcase
			files++;
		end

		s_tvalid = 1'b0;
		while (sb.pending_out.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
